>>> hw/rtl/bddf_pkg.sv
// Shared types, constants and the digit correction function of the display formatter.
`default_nettype none

package bddf_pkg;

    // One packed BCD digit.
    typedef logic [3:0] t_digit;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        CFG_DIGIT_COUNT    = 2'd0,
        CFG_ZERO_FILL      = 2'd1,
        CFG_DIVIDE_PLACES  = 2'd2,
        CFG_DECIMAL_PLACES = 2'd3
    } t_cfg_index;

    // Character codes.
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_POINT = 8'h2E;
    localparam logic [7:0] CHAR_BLANK  = 8'h00;

    // Display geometry.
    localparam int OUT_CHARS   = 6;
    localparam int MAX_CHARS   = 6;
    localparam int LIMIT_CHARS = (MAX_CHARS < OUT_CHARS) ? MAX_CHARS : OUT_CHARS;
    localparam int MAX_DIGITS  = 6;
    localparam int MAX_SPAN    = 8;

    // Shift-and-correct steps done in one converter stage.
    localparam int STEPS_PER_STAGE = 8;

    // Add three to a digit of five or more before the next left shift.
    function automatic t_digit fix_digit(input t_digit d);
        fix_digit = (d >= 4'd5) ? t_digit'(d + 4'd3) : d;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bddf_dabble.sv
// Pipelined binary to BCD converter using shift-and-add-three steps.
`default_nettype none

module bddf_dabble #(
    parameter int NUMBER_WIDTH = 24,
    parameter int BCD_DIGITS   = 8
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [NUMBER_WIDTH-1:0]    i_bin,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic [BCD_DIGITS*4-1:0]    o_bcd
);

    localparam int STEPS  = bddf_pkg::STEPS_PER_STAGE;
    localparam int NSTG   = (NUMBER_WIDTH + STEPS - 1) / STEPS;
    localparam int BCD_W  = BCD_DIGITS * 4;

    logic [NSTG-1:0]                   r_v;
    logic [NSTG-1:0][BCD_W-1:0]        r_bcd;
    logic [NSTG-1:0][NUMBER_WIDTH-1:0] r_bin;
    logic [NSTG-1:0][BCD_W-1:0]        n_bcd;
    logic [NSTG-1:0][NUMBER_WIDTH-1:0] n_bin;
    logic [NSTG-1:0][BCD_W-1:0]        bcd_in;
    logic [NSTG-1:0][NUMBER_WIDTH-1:0] bin_in;
    logic [NSTG-1:0]                   v_in;
    logic [NSTG:0]                     adv;

    // A stage moves when it is empty or the stage after it moves.
    assign adv[NSTG] = ~i_stall;

    genvar s;
    generate
        for (s = 0; s < NSTG; s++) begin : g_stage
            if (s == 0) begin : g_first
                assign bcd_in[s] = '0;
                assign bin_in[s] = i_bin;
                assign v_in[s]   = i_valid;
            end else begin : g_next
                assign bcd_in[s] = r_bcd[s-1];
                assign bin_in[s] = r_bin[s-1];
                assign v_in[s]   = r_v[s-1];
            end

            assign adv[s] = ~r_v[s] | adv[s+1];

            // Up to eight correct-then-shift steps on this stage's slice of the input bits.
            always_comb begin
                logic [BCD_W-1:0]        bcd;
                logic [NUMBER_WIDTH-1:0] bin;
                bcd = bcd_in[s];
                bin = bin_in[s];
                for (int t = 0; t < STEPS; t++) begin
                    if (s * STEPS + t < NUMBER_WIDTH) begin
                        for (int d = 0; d < BCD_DIGITS; d++) begin
                            bcd[d*4 +: 4] = bddf_pkg::fix_digit(bcd[d*4 +: 4]);
                        end
                        {bcd, bin} = {bcd[BCD_W-2:0], bin, 1'b0};
                    end
                end
                n_bcd[s] = bcd;
                n_bin[s] = bin;
            end

            // Valid bit of the stage.
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (adv[s]) begin
                    r_v[s] <= v_in[s];
                end
            end

            // Payload of the stage.
            always_ff @(posedge i_clk) begin
                if (adv[s]) begin
                    r_bcd[s] <= n_bcd[s];
                    r_bin[s] <= n_bin[s];
                end
            end
        end
    endgenerate

    assign o_stall = ~adv[0];
    assign o_valid = r_v[NSTG-1];
    assign o_bcd   = r_bcd[NSTG-1];

endmodule

`default_nettype wire

>>> hw/rtl/binary_to_decimal_display_formatter.sv
// Top level of the binary to decimal display formatter.
//
//   channel  | dir | handshake                      | payload
//   ---------+-----+--------------------------------+------------------------------------
//   input    | in  | i_valid / o_stall              | i_number
//   result   | out | o_valid / i_stall              | o_char_0..5, o_used_length,
//            |     |                                | o_overflow, o_config_error
//   config   | in  | i_cfg_we (no handshake back)   | i_cfg_index, i_cfg_data
//
// One item is taken per cycle while the result side keeps up.
// Each group of up to eight shift-and-add-three steps is a registered stage, followed by
// a registered digit selection stage and then a registered placement stage.
// Empty stages close up under a stall, so o_stall rises only when every stage is full.
// Reset is synchronous and active low; it clears the valid bits and loads the register
// defaults (six digits, blanking, no division, no point).
`default_nettype none

module binary_to_decimal_display_formatter #(
    parameter int NUMBER_WIDTH = 24
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [1:0]              i_cfg_index,
    input  wire  [2:0]              i_cfg_data,
    input  wire                     i_valid,
    output logic                    o_stall,
    input  wire  [NUMBER_WIDTH-1:0] i_number,
    output logic                    o_valid,
    input  wire                     i_stall,
    output logic [7:0]              o_char_0,
    output logic [7:0]              o_char_1,
    output logic [7:0]              o_char_2,
    output logic [7:0]              o_char_3,
    output logic [7:0]              o_char_4,
    output logic [7:0]              o_char_5,
    output logic [2:0]              o_used_length,
    output logic                    o_overflow,
    output logic                    o_config_error
);

    localparam int BCD_MIN    = (NUMBER_WIDTH * 3) / 10 + 1;
    localparam int BCD_DIGITS = (BCD_MIN > bddf_pkg::MAX_SPAN) ? BCD_MIN : bddf_pkg::MAX_SPAN;
    localparam int NCH        = bddf_pkg::OUT_CHARS;
    localparam int NDG        = bddf_pkg::MAX_DIGITS;

    // Configuration registers.
    logic [2:0] r_digit_count;
    logic       r_zero_fill;
    logic [2:0] r_divide_places;
    logic [2:0] r_decimal_places;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count    <= 3'd6;
            r_zero_fill      <= 1'b0;
            r_divide_places  <= 3'd0;
            r_decimal_places <= 3'd0;
        end else if (i_cfg_we) begin
            case (bddf_pkg::t_cfg_index'(i_cfg_index))
                bddf_pkg::CFG_DIGIT_COUNT:    r_digit_count    <= i_cfg_data;
                bddf_pkg::CFG_ZERO_FILL:      r_zero_fill      <= i_cfg_data[0];
                bddf_pkg::CFG_DIVIDE_PLACES:  r_divide_places  <= i_cfg_data;
                bddf_pkg::CFG_DECIMAL_PLACES: r_decimal_places <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Settings check.
    logic       cfg_ok;
    logic [3:0] span;
    logic [3:0] total;
    logic       has_point;

    assign has_point = (r_decimal_places != 3'd0);
    assign span      = {1'b0, r_digit_count} + {1'b0, r_divide_places};
    assign total     = {1'b0, r_digit_count} + {3'b0, has_point};
    assign cfg_ok    = (r_digit_count >= 3'd1) && (r_digit_count <= 3'(NDG))
                    && (span <= 4'(bddf_pkg::MAX_SPAN))
                    && (r_decimal_places < r_digit_count)
                    && (total <= 4'(bddf_pkg::LIMIT_CHARS));

    // Binary to BCD pipeline.
    logic                    dd_valid;
    logic                    dd_stall;
    logic [BCD_DIGITS*4-1:0] dd_bcd;

    bddf_dabble #(
        .NUMBER_WIDTH (NUMBER_WIDTH),
        .BCD_DIGITS   (BCD_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_bin   (i_number),
        .o_valid (dd_valid),
        .i_stall (dd_stall),
        .o_bcd   (dd_bcd)
    );

    // Stage enables from the output back.
    logic adv_out;
    logic adv_a;
    logic r_out_valid;
    logic r_a_valid;

    assign adv_out  = ~r_out_valid | ~i_stall;
    assign adv_a    = ~r_a_valid | adv_out;
    assign dd_stall = ~adv_a;

    // Digit selection: drop the low digits, detect overflow, blank leading zeros.
    logic [NDG-1:0][7:0] n_a_code;
    logic                n_a_over;

    always_comb begin
        bddf_pkg::t_digit [NDG-1:0] qd;
        logic [NDG-1:0]             upper_nz;
        logic                       nz_acc;
        logic                       blank;
        n_a_over = 1'b0;
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if ((dd_bcd[j*4 +: 4] != 4'd0) && (4'(j) >= span)) begin
                n_a_over = 1'b1;
            end
        end
        for (int k = 0; k < NDG; k++) begin
            qd[k] = 4'd0;
            for (int j = 0; j < BCD_DIGITS; j++) begin
                if (4'(j) == ({1'b0, r_divide_places} + 4'(k))) begin
                    qd[k] = dd_bcd[j*4 +: 4];
                end
            end
        end
        nz_acc = 1'b0;
        for (int m = NDG - 1; m >= 0; m--) begin
            nz_acc      = nz_acc | (qd[m] != 4'd0);
            upper_nz[m] = nz_acc;
        end
        for (int k = 0; k < NDG; k++) begin
            blank = !r_zero_fill && (3'(k) > r_decimal_places) && !upper_nz[k];
            if (n_a_over) begin
                n_a_code[k] = bddf_pkg::ASCII_NINE;
            end else if (blank) begin
                n_a_code[k] = bddf_pkg::CHAR_BLANK;
            end else begin
                n_a_code[k] = bddf_pkg::ASCII_ZERO + {4'b0, qd[k]};
            end
        end
    end

    logic [NDG-1:0][7:0] r_a_code;
    logic                r_a_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv_a) begin
            r_a_valid <= dd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_code <= n_a_code;
            r_a_over <= n_a_over;
        end
    end

    // Placement: put digits and the point into character positions.
    logic [NCH-1:0][7:0] n_char;
    logic [2:0]          n_used;
    logic                n_over;
    logic                n_err;

    always_comb begin
        logic [2:0] pt;
        logic [2:0] pos;
        logic [2:0] idx;
        logic [2:0] kk;
        pt = r_digit_count - r_decimal_places;
        for (int p = 0; p < NCH; p++) begin
            pos       = 3'(p);
            idx       = (has_point && (pos > pt)) ? pos - 3'd1 : pos;
            kk        = r_digit_count - 3'd1 - idx;
            n_char[p] = bddf_pkg::CHAR_BLANK;
            if (cfg_ok) begin
                if (has_point && (pos == pt)) begin
                    n_char[p] = bddf_pkg::ASCII_POINT;
                end else if (idx < r_digit_count) begin
                    for (int k = 0; k < NDG; k++) begin
                        if (kk == 3'(k)) begin
                            n_char[p] = r_a_code[k];
                        end
                    end
                end
            end
        end
        n_used = cfg_ok ? total[2:0] : 3'd0;
        n_over = cfg_ok & r_a_over;
        n_err  = ~cfg_ok;
    end

    logic [NCH-1:0][7:0] r_char;
    logic [2:0]          r_used;
    logic                r_over;
    logic                r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_char <= n_char;
            r_used <= n_used;
            r_over <= n_over;
            r_err  <= n_err;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_char_0       = r_char[0];
    assign o_char_1       = r_char[1];
    assign o_char_2       = r_char[2];
    assign o_char_3       = r_char[3];
    assign o_char_4       = r_char[4];
    assign o_char_5       = r_char[5];
    assign o_used_length  = r_used;
    assign o_overflow     = r_over;
    assign o_config_error = r_err;

    // A held selection stage keeps its item until the output side takes it.
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !adv_a |=> r_a_valid)
        else $error("selection stage dropped an item while blocked");

    // An error result carries nothing else.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_config_error |-> (o_used_length == 3'd0) && !o_overflow
            && (o_char_0 == 8'h00) && (o_char_5 == 8'h00))
        else $error("config error result carries data");

    // A good result uses between one and six characters.
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_config_error |-> (o_used_length >= 3'd1) && (o_used_length <= 3'd6))
        else $error("used length out of range");

    // A saturated result never starts with a blank.
    a_over_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> (o_char_0 == bddf_pkg::ASCII_NINE))
        else $error("overflow result not saturated");

endmodule

`default_nettype wire
